FILE: src/lpfs_pkg.sv
// lpfs_pkg: shared types and constants of the length prefixed frame splitter
// no dependencies

package lpfs_pkg;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4086;
   localparam logic [2:0]  HDR_LAST_IDX      = 3'd7;

   typedef struct packed {
      logic [7:0]         payload_byte;
      logic signed [31:0] frame_type;
      logic               first_of_frame;
      logic               last_of_frame;
      logic               empty_frame;
      logic               length_error;
   } lpfs_rsp_type;

endpackage

FILE: src/lpfs_if.sv
// lpfs channel interfaces: byte input, frame result and csr write channels
// depends on lpfs_pkg

interface lpfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpfs_rsp_if;
   import lpfs_pkg::*;
   logic         valid;
   logic         ready;
   lpfs_rsp_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

interface lpfs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_payload;

   modport source (output valid, output max_payload, input ready);
   modport sink   (input valid, input max_payload, output ready);
endinterface

FILE: src/length_prefixed_frame_splitter.sv
// length_prefixed_frame_splitter: one byte per beat, 8-byte header, at most one result per beat
// latency: a payload, empty or error result is valid the cycle after its byte is taken
// throughput: one byte per cycle while the result side does not stall, set by the single output register stage
// reset: synchronous active high; hunts for a header, max_payload back to 4086
// depends on lpfs_pkg and the lpfs channel interfaces

module length_prefixed_frame_splitter #(
   parameter int LENGTH_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   lpfs_req_if.sink     req_chan,
   lpfs_rsp_if.source   rsp_chan,
   lpfs_csr_if.sink     csr_chan
);
   import lpfs_pkg::*;

   localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

   logic [15:0]       max_payload_ff, max_payload_in;
   logic [55:0]       hdr_ff, hdr_in;
   logic [2:0]        hdr_cnt_ff, hdr_cnt_in;
   logic              in_payload_ff, in_payload_in;
   logic [CNT_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [31:0]       held_type_ff, held_type_in;
   logic              first_pend_ff, first_pend_in;
   lpfs_rsp_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_take;
   logic [63:0]       hdr_full;
   logic [31:0]       hdr_type;
   logic [31:0]       hdr_len;
   logic              len_bad;
   logic [CNT_W-1:0]  left_dec;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.beat  = rsp_ff;

   assign hdr_full = {req_chan.data_byte, hdr_ff};
   assign hdr_type = hdr_full[31:0];
   assign hdr_len  = hdr_full[63:32];
   assign len_bad  = hdr_len[31] || (hdr_len > {16'd0, max_payload_ff})
                     || ((hdr_len >> LENGTH_BITS) != 32'd0);
   assign left_dec = bytes_left_ff - 1'b1;

   always_comb begin
      max_payload_in = max_payload_ff;
      hdr_in         = hdr_ff;
      hdr_cnt_in     = hdr_cnt_ff;
      in_payload_in  = in_payload_ff;
      bytes_left_in  = bytes_left_ff;
      held_type_in   = held_type_ff;
      first_pend_in  = first_pend_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      if (csr_chan.valid) begin
         max_payload_in = csr_chan.max_payload;
      end

      if (req_take) begin
         if (in_payload_ff) begin
            bytes_left_in         = left_dec;
            first_pend_in         = 1'b0;
            rsp_valid_in          = 1'b1;
            rsp_in.payload_byte   = req_chan.data_byte;
            rsp_in.frame_type     = held_type_ff;
            rsp_in.first_of_frame = first_pend_ff;
            rsp_in.last_of_frame  = (left_dec == '0);
            rsp_in.empty_frame    = 1'b0;
            rsp_in.length_error   = 1'b0;
            if (left_dec == '0) begin
               in_payload_in = 1'b0;
               hdr_cnt_in    = '0;
            end
         end else begin
            hdr_in = hdr_full[63:8];
            if (hdr_cnt_ff != HDR_LAST_IDX) begin
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
            end else begin
               hdr_cnt_in = '0;
               if (len_bad || hdr_len == 32'd0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.payload_byte   = 8'd0;
                  rsp_in.frame_type     = hdr_type;
                  rsp_in.first_of_frame = 1'b1;
                  rsp_in.last_of_frame  = 1'b1;
                  rsp_in.empty_frame    = !len_bad;
                  rsp_in.length_error   = len_bad;
               end else begin
                  held_type_in  = hdr_type;
                  bytes_left_in = hdr_len[CNT_W-1:0];
                  in_payload_in = 1'b1;
                  first_pend_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         hdr_cnt_ff     <= '0;
         in_payload_ff  <= 1'b0;
         bytes_left_ff  <= '0;
         first_pend_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         hdr_cnt_ff     <= hdr_cnt_in;
         in_payload_ff  <= in_payload_in;
         bytes_left_ff  <= bytes_left_in;
         first_pend_ff  <= first_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      held_type_ff <= held_type_in;
      rsp_ff       <= rsp_in;
   end

   // header collection is idle while payload is running
   a_cnt_idle_in_payload: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (hdr_cnt_ff == 3'd0))
      else $error("header count moved during payload");

   // a running payload always has bytes still to come
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (bytes_left_ff != '0))
      else $error("payload active with no bytes left");

   // every payload byte taken gives a result beat next cycle
   a_payload_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && in_payload_ff) |=> (rsp_valid_ff && !rsp_ff.empty_frame
                                       && !rsp_ff.length_error))
      else $error("payload byte produced no result");

   // empty and error results are single-beat frames and never both
   a_special_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.empty_frame || rsp_ff.length_error)) |->
      (rsp_ff.first_of_frame && rsp_ff.last_of_frame
       && !(rsp_ff.empty_frame && rsp_ff.length_error)))
      else $error("malformed empty or error result");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for the length prefixed frame splitter, with a scoreboard
// class that predicts result beats from accepted bytes and random valid/ready idling
// depends on lpfs_pkg, the lpfs channel interfaces and length_prefixed_frame_splitter

module tb_top;
   import lpfs_pkg::*;

   localparam int          TIMEOUT_NS       = 40_000_000;
   localparam int          DRAIN_CYCLES     = 8;
   localparam int          LONG_HOLD_CYCLES = 300;
   localparam int          SHORT_PAYLOAD    = 24;
   localparam logic [15:0] MAX_PAYLOAD_TOP  = 16'hFFFF;
   localparam logic [31:0] LEN_PAST_FIELD   = 32'h0001_0000;

   class frame_scoreboard;
      lpfs_rsp_type expected_beats[$];
      logic [15:0]  max_payload;
      logic [63:0]  hdr_shift;
      logic [2:0]   hdr_count;
      bit           in_payload;
      logic [15:0]  bytes_left;
      logic [31:0]  held_type;
      bit           first_pending;
      int unsigned  fail_count;

      function new();
         max_payload   = MAX_PAYLOAD_RESET;
         hdr_shift     = '0;
         hdr_count     = '0;
         in_payload    = 1'b0;
         bytes_left    = '0;
         held_type     = '0;
         first_pending = 1'b0;
         fail_count    = 0;
      endfunction

      function bit at_frame_start();
         return !in_payload && hdr_count == '0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // one accepted input byte, queues the beat it causes if any
      function void take_byte(logic [7:0] value);
         lpfs_rsp_type beat;
         logic [31:0]  hdr_type;
         logic [31:0]  hdr_len;
         beat = '0;
         if (in_payload) begin
            bytes_left          = bytes_left - 16'd1;
            beat.payload_byte   = value;
            beat.frame_type     = held_type;
            beat.first_of_frame = first_pending;
            beat.last_of_frame  = (bytes_left == '0);
            first_pending       = 1'b0;
            if (bytes_left == '0) begin
               in_payload = 1'b0;
               hdr_count  = '0;
            end
            expected_beats.push_back(beat);
            return;
         end
         hdr_shift = {value, hdr_shift[63:8]};
         if (hdr_count != HDR_LAST_IDX) begin
            hdr_count = hdr_count + 3'd1;
            return;
         end
         hdr_count = '0;
         hdr_type  = hdr_shift[31:0];
         hdr_len   = hdr_shift[63:32];
         // a 16-bit limit also covers lengths too wide for the counter
         if (hdr_len[31] || hdr_len > {16'd0, max_payload}) begin
            beat.frame_type     = hdr_type;
            beat.first_of_frame = 1'b1;
            beat.last_of_frame  = 1'b1;
            beat.length_error   = 1'b1;
            expected_beats.push_back(beat);
         end else if (hdr_len == '0) begin
            beat.frame_type     = hdr_type;
            beat.first_of_frame = 1'b1;
            beat.last_of_frame  = 1'b1;
            beat.empty_frame    = 1'b1;
            expected_beats.push_back(beat);
         end else begin
            held_type     = hdr_type;
            bytes_left    = hdr_len[15:0];
            in_payload    = 1'b1;
            first_pending = 1'b1;
         end
      endfunction

      function void check_beat(lpfs_rsp_type got);
         lpfs_rsp_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: type %0d byte %0h",
                   got.frame_type, got.payload_byte);
            fail_count++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
            fail_count++;
         end
         if (got.frame_type !== want.frame_type) begin
            $error("frame_type: expected %0d, actual %0d", want.frame_type, got.frame_type);
            fail_count++;
         end
         if (got.first_of_frame !== want.first_of_frame) begin
            $error("first_of_frame: expected %0b, actual %0b",
                   want.first_of_frame, got.first_of_frame);
            fail_count++;
         end
         if (got.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b",
                   want.last_of_frame, got.last_of_frame);
            fail_count++;
         end
         if (got.empty_frame !== want.empty_frame) begin
            $error("empty_frame: expected %0b, actual %0b", want.empty_frame, got.empty_frame);
            fail_count++;
         end
         if (got.length_error !== want.length_error) begin
            $error("length_error: expected %0b, actual %0b",
                   want.length_error, got.length_error);
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   bit   hold_request;
   int   bytes_sent;

   frame_scoreboard sb = new();

   lpfs_req_if req_if ();
   lpfs_rsp_if rsp_if ();
   lpfs_csr_if csr_if ();

   length_prefixed_frame_splitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_beat(rsp_if.beat);
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < 30) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      sb.take_byte(value);
      bytes_sent++;
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // first n bytes of a header, type word then length, little-endian
   task automatic send_header(input logic [31:0] frame_type, input logic [31:0] frame_len,
                              input int n);
      logic [63:0] hdr;
      hdr = {frame_len, frame_type};
      for (int i = 0; i < n; i++) send_byte(hdr[8*i +: 8]);
   endtask

   task automatic send_frame(input logic [31:0] frame_type, input logic [31:0] frame_len);
      send_header(frame_type, frame_len, 8);
      for (int i = 0; i < int'(frame_len); i++) send_byte(8'($urandom));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_payload(input logic [15:0] value);
      csr_if.valid       <= 1'b1;
      csr_if.max_payload <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.max_payload = value;
   endtask

   task automatic random_frame();
      logic [31:0] frame_type;
      logic [31:0] frame_len;
      int          cap;
      int          kind;
      // garbage until the splitter is hunting at a header boundary
      while (!sb.at_frame_start()) send_byte(8'($urandom));
      frame_type = $urandom;
      kind       = $urandom_range(0, 99);
      cap        = (sb.max_payload < SHORT_PAYLOAD) ? int'(sb.max_payload) : SHORT_PAYLOAD;
      if (kind < 60) begin
         frame_len = (cap == 0) ? 32'd0 : 32'($urandom_range(1, cap));
         send_frame(frame_type, frame_len);
      end else if (kind < 70) begin
         send_frame(frame_type, 32'd0);
      end else if (kind < 80) begin
         case ($urandom_range(0, 2))
            0: frame_len = {1'b1, 31'($urandom)};
            1: frame_len = {16'd0, sb.max_payload} + 32'd1 + 32'($urandom_range(0, 20));
            default: frame_len = $urandom_range(LEN_PAST_FIELD, 32'h7FFF_FFFF);
         endcase
         send_header(frame_type, frame_len, 8);
      end else if (kind < 90) begin
         // broken header, cut short
         frame_len = (cap == 0) ? 32'd0 : 32'($urandom_range(1, cap));
         send_header(frame_type, frame_len, $urandom_range(1, 7));
      end else begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end
   endtask

   task automatic run_random(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) random_frame();
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.data_byte   <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.max_payload <= '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      bytes_sent   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed, reset limit
      send_frame(32'h8000_0000, 32'd0);
      send_header(32'h7FFF_FFFF, 32'd1, 8);
      send_byte(8'hFF);
      send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_header(32'h0000_0000, {16'd0, MAX_PAYLOAD_RESET} + 32'd1, 8);
      send_header(32'h1234_5678, 32'd2, 8);
      send_byte(8'h00);
      send_byte(8'h5A);
      run_random(150);
      wait_drained();

      write_max_payload(16'd0);
      send_frame($urandom, 32'd1);
      run_random(120);
      wait_drained();

      write_max_payload(MAX_PAYLOAD_TOP);
      send_header($urandom, LEN_PAST_FIELD, 8);
      run_random(200);
      wait_drained();

      write_max_payload(16'($urandom_range(1, SHORT_PAYLOAD)));
      send_frame($urandom, {16'd0, sb.max_payload});
      hold_request = 1'b1;
      run_random(200);
      wait_drained();

      // last part with no idling on either side
      quiet = 1'b1;
      write_max_payload(16'($urandom_range(SHORT_PAYLOAD + 1, MAX_PAYLOAD_RESET)));
      run_random(150);
      wait_drained();

      if (sb.fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
